// File: src/obbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package obbp_pkg;

  typedef enum logic {
    ACT_ACQUIRE    = 1'b0,
    ACT_INVALIDATE = 1'b1
  } obbp_action_e;

  typedef struct packed {
    obbp_action_e action;
    logic [31:0]  owner_id;
    logic [31:0]  block_number;
  } obbp_req_t;

  typedef struct packed {
    logic [2:0] buffer_index;
    logic       need_load;
    logic       was_evicted;
    logic [3:0] cleared_count;
  } obbp_res_t;

  // acquire decision flags
  typedef struct packed {
    logic owned_hit;
    logic free_hit;
    logic evict;
    logic load;
  } obbp_pick_t;

  localparam logic [31:0] FREE_OWNER = 32'd0;
  localparam logic [3:0]  CLEAR_SAT  = 4'd15;

endpackage

`default_nettype wire

// File: src/obbp_select.sv
`timescale 1ns / 1ps
`default_nettype none

module obbp_select import obbp_pkg::*; #(
  parameter int BUFFER_COUNT = 8,
  parameter int IDX_W        = 3
) (
  input  obbp_req_t         req_i,
  input  logic [31:0]       owner_tbl_i [BUFFER_COUNT],
  input  logic [31:0]       addr_tbl_i  [BUFFER_COUNT],
  input  logic [IDX_W-1:0]  victim_i,
  output obbp_pick_t        pick_o,
  output logic [IDX_W-1:0]  idx_o,
  output logic [IDX_W-1:0]  victim_next_o,
  output logic [BUFFER_COUNT-1:0] addr_match_o,
  output logic [3:0]        cleared_count_o
);

  localparam int CNT_W = $clog2(BUFFER_COUNT + 1);

  logic [BUFFER_COUNT-1:0] own_match;
  logic [BUFFER_COUNT-1:0] free_match;
  logic [IDX_W-1:0]        own_idx;
  logic [IDX_W-1:0]        free_idx;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W+3:0]        cnt_ext;
  logic [BUFFER_COUNT-1:0] hit_sel;

  function automatic logic [IDX_W-1:0] lowest(input logic [BUFFER_COUNT-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = BUFFER_COUNT - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = IDX_W'(i);
      end
    end
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < BUFFER_COUNT; i++) begin
      own_match[i]    = (owner_tbl_i[i] == req_i.owner_id);
      free_match[i]   = (owner_tbl_i[i] == FREE_OWNER);
      addr_match_o[i] = (addr_tbl_i[i] == req_i.block_number);
    end
    own_idx  = lowest(own_match);
    free_idx = lowest(free_match);

    if (victim_i == IDX_W'(BUFFER_COUNT - 1)) begin
      victim_next_o = '0;
    end else begin
      victim_next_o = victim_i + 1'b1;
    end

    pick_o.owned_hit = |own_match;
    pick_o.free_hit  = !pick_o.owned_hit && (|free_match);
    pick_o.evict     = !pick_o.owned_hit && !(|free_match);

    if (pick_o.owned_hit) begin
      idx_o = own_idx;
    end else if (pick_o.free_hit) begin
      idx_o = free_idx;
    end else begin
      idx_o = victim_next_o;
    end

    // address mismatch of the owned entry; claimed entries start at zero
    for (int i = 0; i < BUFFER_COUNT; i++) begin
      hit_sel[i] = (idx_o == IDX_W'(i)) && !addr_match_o[i];
    end
    if (pick_o.owned_hit) begin
      pick_o.load = |hit_sel;
    end else begin
      pick_o.load = (req_i.block_number != 32'd0);
    end

    cnt = '0;
    for (int i = 0; i < BUFFER_COUNT; i++) begin
      cnt = cnt + CNT_W'(addr_match_o[i]);
    end
    cnt_ext = {4'd0, cnt};
    if (cnt_ext > (CNT_W + 4)'(CLEAR_SAT)) begin
      cleared_count_o = CLEAR_SAT;
    end else begin
      cleared_count_o = cnt_ext[3:0];
    end
  end

endmodule

`default_nettype wire

// File: src/owned_block_buffer_policy_unit.sv
// channel  | ports                    | handshake
// ---------+--------------------------+---------------------------------
// request  | start_i, busy_o, req_i   | taken when start_i && !busy_o
// result   | done_o, res_o            | valid for one cycle on done_o
//
// An item is taken in any cycle; busy_o stays low.
// Its result goes through the input register, then lookup and table update
// into the result register, from which it is on the ports. Items follow back
// to back.
// Reset clears owners, addresses, victim pointer and valid flags at once.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module owned_block_buffer_policy_unit import obbp_pkg::*; #(
  parameter int BUFFER_COUNT = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  obbp_req_t req_i,
  output logic      done_o,
  output obbp_res_t res_o
);

  localparam int IDX_W = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;

  logic                    req_valid_q;
  obbp_req_t               req_q;
  logic [31:0]             owner_q [BUFFER_COUNT];
  logic [31:0]             addr_q  [BUFFER_COUNT];
  logic [IDX_W-1:0]        victim_q;
  logic                    done_q;
  obbp_res_t               res_q;

  obbp_pick_t              pick;
  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        victim_next;
  logic [BUFFER_COUNT-1:0] addr_match;
  logic [3:0]              cleared_count;
  logic [IDX_W+2:0]        idx_ext;
  logic                    is_inval;
  obbp_res_t               res_d;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= req_i;
    end
  end

  obbp_select #(
    .BUFFER_COUNT(BUFFER_COUNT),
    .IDX_W       (IDX_W)
  ) u_select (
    .req_i          (req_q),
    .owner_tbl_i    (owner_q),
    .addr_tbl_i     (addr_q),
    .victim_i       (victim_q),
    .pick_o         (pick),
    .idx_o          (idx),
    .victim_next_o  (victim_next),
    .addr_match_o   (addr_match),
    .cleared_count_o(cleared_count)
  );

  assign is_inval = (req_q.action == ACT_INVALIDATE);
  assign idx_ext  = {3'd0, idx};

  always_comb begin
    if (is_inval) begin
      res_d.buffer_index  = 3'd0;
      res_d.need_load     = 1'b0;
      res_d.was_evicted   = 1'b0;
      res_d.cleared_count = cleared_count;
    end else begin
      res_d.buffer_index  = idx_ext[2:0];
      res_d.need_load     = pick.load;
      res_d.was_evicted   = pick.evict;
      res_d.cleared_count = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUFFER_COUNT; i++) begin
        owner_q[i] <= FREE_OWNER;
        addr_q[i]  <= 32'd0;
      end
      victim_q <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= req_valid_q;
      if (req_valid_q) begin
        if (is_inval) begin
          for (int i = 0; i < BUFFER_COUNT; i++) begin
            if (addr_match[i]) begin
              addr_q[i] <= 32'd0;
            end
          end
        end else begin
          for (int i = 0; i < BUFFER_COUNT; i++) begin
            if (idx == IDX_W'(i)) begin
              addr_q[i] <= req_q.block_number;
              if (!pick.owned_hit) begin
                owner_q[i] <= req_q.owner_id;
              end
            end
          end
          if (pick.evict) begin
            victim_q <= victim_next;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  logic [IDX_W+2:0] victim_ext;
  assign victim_ext = {3'd0, victim_q};

  a_done_follows_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(req_valid_q))
    else $error("result without a registered item");

  a_evict_uses_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.was_evicted) |-> (res_q.buffer_index == victim_ext[2:0]))
    else $error("evicted buffer differs from victim pointer");

  a_inval_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.cleared_count != 4'd0) |->
      (res_q.buffer_index == 3'd0 && !res_q.need_load && !res_q.was_evicted))
    else $error("invalidate result carries acquire fields");

  a_victim_moves_on_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && !is_inval && !pick.evict) |=> $stable(victim_q))
    else $error("victim pointer moved without eviction");
`endif

endmodule

`default_nettype wire
